>>> src/wrm_pkg.sv
// ----------------------------------------------------------------------------
// wrm_pkg
// Shared types and constants for the wildcard pattern matcher: command codes,
// wildcard bytes, control FSM states and the link between neighboring cells.
// ----------------------------------------------------------------------------
package wrm_pkg;

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] DOT_BYTE  = 8'h2E;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_TEXT    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  // Update wave handed from cell j-1 to cell j.
  typedef struct packed {
    logic tok;    // wave is at this cell
    logic new_a;  // updated match bit of cell j-1
    logic new_b;  // updated match bit of cell j-2
    logic old_a;  // match bit of cell j-1 before the update
  } link_t;

endpackage

>>> src/wrm_cell.sv
// ----------------------------------------------------------------------------
// wrm_cell
// One pattern position: holds a pattern byte, its star flag, an occupied bit
// and the match bit of the prefix ending here. Updates its match bit when the
// wave reaches it and passes the wave on to the next cell.
// ----------------------------------------------------------------------------
module wrm_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           clear,
  input  logic           append,
  input  logic [7:0]     wr_byte,
  input  logic           star_ok,
  input  logic           occ_left,
  input  logic [7:0]     left_byte,
  input  logic [7:0]     text_byte,
  input  logic           restart,
  input  wrm_pkg::link_t link_in,
  output wrm_pkg::link_t link_out,
  output logic           occ,
  output logic [7:0]     pat,
  output logic           match
);
  import wrm_pkg::*;

  logic       is_star;
  logic       tok;
  logic       new_a;
  logic       new_b;
  logic       old_a;
  logic       write;
  logic       active;
  logic [7:0] atom;
  logic       hit;
  logic       nxt;

  // occupancy is a prefix, so only the first free cell takes the append
  assign write  = append & occ_left & ~occ;
  assign active = link_in.tok & occ;

  // a star cell repeats the byte held one cell to the left
  assign atom = is_star ? left_byte : pat;
  assign hit  = ~restart & ((atom == DOT_BYTE) | (atom == text_byte));
  assign nxt  = is_star ? (link_in.new_b | (match & hit)) : (link_in.old_a & hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
      tok <= 1'b0;
    end else begin
      if (clear) begin
        occ <= 1'b0;
      end else if (write) begin
        occ <= 1'b1;
      end
      tok <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (write) begin
      pat     <= wr_byte;
      is_star <= star_ok & (wr_byte == STAR_BYTE);
    end
    if (active) begin
      match <= nxt;
      new_a <= nxt;
      new_b <= link_in.new_a;
      old_a <= match;
    end
  end

  assign link_out = '{tok: tok, new_a: new_a, new_b: new_b, old_a: old_a};

endmodule

>>> src/wildcard_regex_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_regex_matcher
// Streaming matcher for patterns with '.' (any byte) and 'x*' (zero or more x).
// ----------------------------------------------------------------------------
// Every accepted command gives one result: whether the text since the last
// restart, append or clear matches the whole loaded pattern, and whether an
// append was dropped because the pattern is full. The pattern lives in a row
// of cells, one per pattern byte, each with the match bit of its prefix. A
// text byte, restart or successful append sends an update wave down the row,
// one cell per cycle; clear and a dropped append send none. One item is
// processed at a time; a new item is taken while the previous result still
// waits in the output register.
module wildcard_regex_matcher #(
  parameter int MAX_PATTERN = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  input  logic [7:0] symbol,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       matched,
  output logic       pattern_overflow
);
  import wrm_pkg::*;

  localparam int LW = $clog2(MAX_PATTERN + 1);

  state_t      state;
  state_t      state_next;
  cmd_t        cmd;
  logic [LW-1:0] length;
  logic [LW-1:0] cnt;
  logic        row0;
  link_t       head;
  logic        restart_mode;
  logic [7:0]  text_byte;
  logic        ovf;
  logic        full;
  logic        accept;
  logic        load_out;
  logic        do_clear;
  logic        do_append;
  logic        launch;

  link_t              link [MAX_PATTERN+1];
  logic               occ_vec [MAX_PATTERN+1];
  logic [7:0]         byte_vec [MAX_PATTERN+1];
  logic [MAX_PATTERN:0] row;

  assign cmd  = cmd_t'(command);
  assign full = (length == LW'(MAX_PATTERN));

  assign link[0]     = head;
  assign occ_vec[0]  = 1'b1;
  assign byte_vec[0] = 8'h00;
  assign row[0]      = row0;

  for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_cell
    wrm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .clear     (do_clear),
      .append    (do_append),
      .wr_byte   (symbol),
      .star_ok   ((j >= 2) ? 1'b1 : 1'b0),
      .occ_left  (occ_vec[j-1]),
      .left_byte (byte_vec[j-1]),
      .text_byte (text_byte),
      .restart   (restart_mode),
      .link_in   (link[j-1]),
      .link_out  (link[j]),
      .occ       (occ_vec[j]),
      .pat       (byte_vec[j]),
      .match     (row[j])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd)
            CMD_CLEAR:  state_next = ST_FINISH;
            CMD_APPEND: state_next = full ? ST_FINISH : ST_RUN;
            default:    state_next = (length == '0) ? ST_FINISH : ST_RUN;
          endcase
        end
      end
      ST_RUN: begin
        if (cnt == length) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = (state == ST_IDLE);
    accept    = in_ready & in_valid;
    load_out  = (state == ST_FINISH) & (~out_valid | out_ready);
    do_clear  = accept & (cmd == CMD_CLEAR);
    do_append = accept & (cmd == CMD_APPEND) & ~full;
    launch    = accept & (cmd != CMD_CLEAR) & ~((cmd == CMD_APPEND) & full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      length    <= '0;
      row0      <= 1'b1;
      head.tok  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      head.tok <= launch;
      if (accept) begin
        head.new_a <= (cmd != CMD_TEXT);
        head.new_b <= 1'b0;
        head.old_a <= row0;
      end
      if (do_clear) begin
        length <= '0;
      end else if (do_append) begin
        length <= length + LW'(1);
      end
      if (do_clear | launch) begin
        row0 <= (cmd != CMD_TEXT);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cnt          <= LW'(1);
      restart_mode <= (cmd != CMD_TEXT);
      text_byte    <= symbol;
      ovf          <= (cmd == CMD_APPEND) & full;
    end else if (state == ST_RUN) begin
      cnt <= cnt + LW'(1);
    end
    if (load_out) begin
      matched          <= row[length];
      pattern_overflow <= ovf;
    end
  end

endmodule
